// ===== hw/rtl/brle_pkg.sv =====
`default_nettype none

package brle_pkg;

  // Results kept per input word; later results of the same input are dropped.
  localparam int unsigned RESULT_CAP = 24;
  localparam int unsigned RC_W = 5;
  localparam logic [RC_W-1:0] RC_LAST = RC_W'(RESULT_CAP - 1);

  // Header byte layout.
  localparam logic [7:0] HDR_LEN_MASK = 8'h7f;
  localparam logic [7:0] HDR_REPEAT = 8'h80;

  // Packet lengths that the scanner produces as fixed cases.
  localparam logic [7:0] LONE_LEN = 8'd1;
  localparam logic [7:0] PAIR_LEN = 8'd2;
  localparam logic [7:0] TRIPLE_LEN = 8'd3;

  // What sits at the front of the window.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_LIT  = 2'd1,
    KIND_REP  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_READ,
    EM_SEND
  } em_state_e;

  // Packets settled by one input word: a first packet and an optional second.
  typedef struct packed {
    logic       start;
    logic       at_end;
    logic       a_rep;
    logic [7:0] a_len;
    logic       b_pend;
    logic       b_rep;
    logic [7:0] rep_byte;
  } plan_t;

  function automatic logic [7:0] hdr_byte(input logic rep, input logic [7:0] len);
    logic [7:0] len_m1;
    len_m1 = len - 8'd1;
    return rep ? (HDR_REPEAT | (len_m1 & HDR_LEN_MASK)) : (len_m1 & HDR_LEN_MASK);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/brle_if.sv =====
`default_nettype none

interface brle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_in_block;

  modport source (output valid, output data_byte, output last_in_block, input ready);
  modport sink (input valid, input data_byte, input last_in_block, output ready);
endinterface

interface brle_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  valid_bytes;
  logic        ends_packet;
  logic        ends_block;
  logic        last_of_run;

  modport source (output valid, output out_bytes, output valid_bytes, output ends_packet,
                  output ends_block, output last_of_run, input ready);
  modport sink (input valid, input out_bytes, input valid_bytes, input ends_packet,
                input ends_block, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/brle_window_ram.sv =====
`default_nettype none

// Window store: one row per output word, one byte lane per output lane.
// Byte-wide writes, one registered row read per cycle.
module brle_window_ram #(
  parameter int unsigned MAX_PACKET = 128,
  parameter int unsigned OUT_LANES = 8,
  localparam int unsigned ROWS = (MAX_PACKET + 1) / OUT_LANES + 1,
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int unsigned LANE_W = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ROW_W-1:0]            wr_row_i,
  input  logic [LANE_W-1:0]           wr_lane_i,
  input  logic [7:0]                  wr_data_i,
  input  logic                        rd_en_i,
  input  logic [ROW_W-1:0]            rd_row_i,
  output logic [OUT_LANES-1:0][7:0]   rd_data_o
);

  logic [OUT_LANES-1:0][7:0] window_q [ROWS];
  logic [OUT_LANES-1:0][7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      window_q[wr_row_i][wr_lane_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= window_q[rd_row_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/brle_scan.sv =====
`default_nettype none

// Front-of-window tracker. Keeps the pending count, the kind of the front
// packet and the last two bytes, and settles packets as each byte arrives.
// Literal bytes go into the window RAM at their position within the packet
// (position zero is the header).
module brle_scan #(
  parameter int unsigned MAX_PACKET = 128,
  parameter int unsigned OUT_LANES = 8,
  localparam int unsigned ROWS = (MAX_PACKET + 1) / OUT_LANES + 1,
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int unsigned LANE_W = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_i,
  output brle_pkg::plan_t       plan_o,
  output logic                  we_o,
  output logic [ROW_W-1:0]      wr_row_o,
  output logic [LANE_W-1:0]     wr_lane_o,
  output logic [7:0]            wr_data_o
);

  localparam logic [7:0] MAX_N = 8'(MAX_PACKET);
  localparam logic [ROW_W-1:0] POS1_ROW = ROW_W'(1 / OUT_LANES);
  localparam logic [LANE_W-1:0] POS1_LANE = LANE_W'(1 % OUT_LANES);
  localparam logic [ROW_W-1:0] POS2_ROW = ROW_W'(2 / OUT_LANES);
  localparam logic [LANE_W-1:0] POS2_LANE = LANE_W'(2 % OUT_LANES);
  localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(OUT_LANES - 1);

  logic [7:0]        cnt_q, cnt_d;
  brle_pkg::kind_e   kind_q, kind_d;
  logic [7:0]        p1_q, p2_q;
  logic [ROW_W-1:0]  wrow_q, wrow_d;
  logic [LANE_W-1:0] wlane_q, wlane_d;

  logic [7:0] n_cnt;
  logic       flush, same1, triple, rep_mis, wr, emit;
  brle_pkg::plan_t plan;

  always_comb begin
    n_cnt   = cnt_q + 8'd1;
    flush   = last_i || (n_cnt == MAX_N);
    same1   = (data_byte_i == p1_q);
    triple  = same1 && (p1_q == p2_q);
    rep_mis = 1'b0;
    wr      = 1'b1;
    emit    = 1'b0;
    cnt_d   = cnt_q;
    kind_d  = kind_q;
    plan    = '0;

    case (kind_q)
      brle_pkg::KIND_NONE: begin
        if (cnt_q == 8'd0) begin
          if (last_i) begin
            emit       = 1'b1;
            plan.a_len = brle_pkg::LONE_LEN;
            cnt_d      = 8'd0;
          end else begin
            cnt_d = 8'd1;
          end
        end else begin
          if (flush) begin
            emit          = 1'b1;
            plan.a_rep    = same1;
            plan.a_len    = brle_pkg::PAIR_LEN;
            plan.rep_byte = p1_q;
            cnt_d         = 8'd0;
          end else begin
            cnt_d  = n_cnt;
            kind_d = same1 ? brle_pkg::KIND_REP : brle_pkg::KIND_LIT;
          end
        end
      end
      brle_pkg::KIND_REP: begin
        if (same1) begin
          // Run continues; its bytes are never read back.
          wr = 1'b0;
          if (flush) begin
            emit          = 1'b1;
            plan.a_rep    = 1'b1;
            plan.a_len    = n_cnt;
            plan.rep_byte = p1_q;
            cnt_d         = 8'd0;
            kind_d        = brle_pkg::KIND_NONE;
          end else begin
            cnt_d = n_cnt;
          end
        end else begin
          // Run broken: the new byte opens a fresh window at position one.
          rep_mis       = 1'b1;
          emit          = 1'b1;
          plan.a_rep    = 1'b1;
          plan.a_len    = cnt_q;
          plan.rep_byte = p1_q;
          kind_d        = brle_pkg::KIND_NONE;
          if (last_i) begin
            plan.b_pend = 1'b1;
            cnt_d       = 8'd0;
          end else begin
            cnt_d = 8'd1;
          end
        end
      end
      brle_pkg::KIND_LIT: begin
        if (triple) begin
          // Three equal bytes end the literal and start a run.
          emit       = 1'b1;
          plan.a_len = cnt_q - 8'd2;
          if (last_i) begin
            plan.b_pend   = 1'b1;
            plan.b_rep    = 1'b1;
            plan.rep_byte = data_byte_i;
            cnt_d         = 8'd0;
            kind_d        = brle_pkg::KIND_NONE;
          end else begin
            cnt_d  = brle_pkg::TRIPLE_LEN;
            kind_d = brle_pkg::KIND_REP;
          end
        end else if (flush) begin
          emit       = 1'b1;
          plan.a_len = n_cnt;
          cnt_d      = 8'd0;
          kind_d     = brle_pkg::KIND_NONE;
        end else begin
          cnt_d = n_cnt;
        end
      end
      default: begin
        wr     = 1'b0;
        cnt_d  = 8'd0;
        kind_d = brle_pkg::KIND_NONE;
      end
    endcase

    plan.at_end = last_i;
    plan.start  = emit && accept_i;

    if (cnt_d == 8'd0) begin
      wrow_d  = POS1_ROW;
      wlane_d = POS1_LANE;
    end else if (rep_mis) begin
      wrow_d  = POS2_ROW;
      wlane_d = POS2_LANE;
    end else if (wr) begin
      if (wlane_q == LANE_LAST) begin
        wlane_d = '0;
        wrow_d  = ROW_W'(wrow_q + 1'b1);
      end else begin
        wlane_d = LANE_W'(wlane_q + 1'b1);
        wrow_d  = wrow_q;
      end
    end else begin
      wrow_d  = wrow_q;
      wlane_d = wlane_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 8'd0;
      kind_q  <= brle_pkg::KIND_NONE;
      wrow_q  <= POS1_ROW;
      wlane_q <= POS1_LANE;
    end else if (accept_i) begin
      cnt_q   <= cnt_d;
      kind_q  <= kind_d;
      wrow_q  <= wrow_d;
      wlane_q <= wlane_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      p2_q <= p1_q;
      p1_q <= data_byte_i;
    end
  end

  assign plan_o    = plan;
  assign we_o      = accept_i && wr;
  assign wr_row_o  = rep_mis ? POS1_ROW : wrow_q;
  assign wr_lane_o = rep_mis ? POS1_LANE : wlane_q;
  assign wr_data_o = data_byte_i;

endmodule

`default_nettype wire

// ===== hw/rtl/brle_emit.sv =====
`default_nettype none

// Packet emitter. Walks the rows of a settled packet, one RAM read per
// result word, and places the header in lane zero of the first word.
module brle_emit #(
  parameter int unsigned MAX_PACKET = 128,
  parameter int unsigned OUT_LANES = 8,
  localparam int unsigned ROWS = (MAX_PACKET + 1) / OUT_LANES + 1,
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  brle_pkg::plan_t            plan_i,
  output logic                       busy_o,
  output logic                       rd_en_o,
  output logic [ROW_W-1:0]           rd_row_o,
  input  logic [OUT_LANES-1:0][7:0]  rd_data_i,
  brle_out_if.source                 out_o
);

  localparam logic [7:0] LANES_B = 8'(OUT_LANES);

  brle_pkg::em_state_e st_q, st_d;
  logic                     cur_rep_q, cur_rep_d;
  logic [7:0]               hdr_q, hdr_d;
  logic [7:0]               rem_q, rem_d;
  logic [ROW_W-1:0]         row_q, row_d;
  logic                     b_pend_q, b_pend_d;
  logic                     b_rep_q, b_rep_d;
  logic [7:0]               rep_byte_q, rep_byte_d;
  logic                     at_end_q, at_end_d;
  logic [brle_pkg::RC_W-1:0] rc_q, rc_d;

  logic        ovalid_q;
  logic [63:0] obytes_q;
  logic [3:0]  ovb_q;
  logic        oep_q, oeb_q, olr_q;

  logic        load, ends_pkt, is_last;
  logic [3:0]  vb;
  logic [63:0] word;

  always_comb begin
    ends_pkt = (rem_q <= LANES_B);
    is_last  = (ends_pkt && !b_pend_q) || (rc_q == brle_pkg::RC_LAST);
    vb       = ends_pkt ? rem_q[3:0] : 4'(OUT_LANES);

    word = '0;
    for (int j = 0; j < OUT_LANES; j++) begin
      if (4'(j) < vb) begin
        if ((row_q == '0) && (j == 0)) begin
          word[8*j +: 8] = hdr_q;
        end else if (cur_rep_q) begin
          word[8*j +: 8] = rep_byte_q;
        end else begin
          word[8*j +: 8] = rd_data_i[j];
        end
      end
    end
  end

  always_comb begin
    st_d       = st_q;
    cur_rep_d  = cur_rep_q;
    hdr_d      = hdr_q;
    rem_d      = rem_q;
    row_d      = row_q;
    b_pend_d   = b_pend_q;
    b_rep_d    = b_rep_q;
    rep_byte_d = rep_byte_q;
    at_end_d   = at_end_q;
    rc_d       = rc_q;
    rd_en_o    = 1'b0;
    load       = 1'b0;

    case (st_q)
      brle_pkg::EM_IDLE: begin
        if (plan_i.start) begin
          cur_rep_d  = plan_i.a_rep;
          hdr_d      = brle_pkg::hdr_byte(plan_i.a_rep, plan_i.a_len);
          rem_d      = plan_i.a_rep ? brle_pkg::PAIR_LEN : (plan_i.a_len + 8'd1);
          row_d      = '0;
          b_pend_d   = plan_i.b_pend;
          b_rep_d    = plan_i.b_rep;
          rep_byte_d = plan_i.rep_byte;
          at_end_d   = plan_i.at_end;
          rc_d       = '0;
          st_d       = brle_pkg::EM_READ;
        end
      end
      brle_pkg::EM_READ: begin
        rd_en_o = 1'b1;
        st_d    = brle_pkg::EM_SEND;
      end
      brle_pkg::EM_SEND: begin
        if (!ovalid_q || out_o.ready) begin
          load = 1'b1;
          rc_d = brle_pkg::RC_W'(rc_q + 1'b1);
          if (is_last) begin
            st_d = brle_pkg::EM_IDLE;
          end else if (ends_pkt) begin
            // Second packet of the same input: a three-byte run or a lone literal.
            cur_rep_d = b_rep_q;
            hdr_d     = b_rep_q ? brle_pkg::hdr_byte(1'b1, brle_pkg::TRIPLE_LEN)
                                : brle_pkg::hdr_byte(1'b0, brle_pkg::LONE_LEN);
            rem_d     = brle_pkg::PAIR_LEN;
            row_d     = '0;
            b_pend_d  = 1'b0;
            st_d      = brle_pkg::EM_READ;
          end else begin
            rem_d = rem_q - LANES_B;
            row_d = ROW_W'(row_q + 1'b1);
            st_d  = brle_pkg::EM_READ;
          end
        end
      end
      default: begin
        st_d = brle_pkg::EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= brle_pkg::EM_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_rep_q  <= cur_rep_d;
    hdr_q      <= hdr_d;
    rem_q      <= rem_d;
    row_q      <= row_d;
    b_pend_q   <= b_pend_d;
    b_rep_q    <= b_rep_d;
    rep_byte_q <= rep_byte_d;
    at_end_q   <= at_end_d;
    rc_q       <= rc_d;
    if (load) begin
      obytes_q <= word;
      ovb_q    <= vb;
      oep_q    <= ends_pkt;
      olr_q    <= is_last;
      oeb_q    <= is_last && at_end_q;
    end
  end

  assign busy_o            = (st_q != brle_pkg::EM_IDLE);
  assign rd_row_o          = row_q;
  assign out_o.valid       = ovalid_q;
  assign out_o.out_bytes   = obytes_q;
  assign out_o.valid_bytes = ovb_q;
  assign out_o.ends_packet = oep_q;
  assign out_o.ends_block  = oeb_q;
  assign out_o.last_of_run = olr_q;

endmodule

`default_nettype wire

// ===== hw/rtl/byte_run_rle_encoder_top.sv =====
`default_nettype none

// Channel   Dir  Word contents
// in_i      in   data_byte, last_in_block (one raw byte, block-end flag)
// out_o     out  out_bytes, valid_bytes, ends_packet, ends_block, last_of_run
//
// A byte that settles no packet leaves the input ready, so the next byte can
// follow in the cycle after it. A byte that settles packets holds the input
// off while each result word takes a window RAM row read and then a load of
// the output register. At most two packets are settled by one byte.
// Reset clears the scanner and emitter control state only; the window RAM is
// never cleared, since only positions written in the current packet are read.
// A stalled output holds the emitter in its send state; bytes are taken again
// as soon as the last word of the byte is in the output register.
//
// The byte-run scheme: a packet starts with a header byte whose low seven bits
// hold the length minus one and whose top bit marks a repeat. A repeat packet
// carries one data byte, a literal packet carries all of its bytes. The
// scanner tracks the front of the window incrementally (count, kind and the
// last two bytes), so each byte is settled with a few byte compares. Literal
// bytes are stored in the window RAM at their packet position, laid out as
// rows of OUT_LANES bytes so that each result word is a single row read.
module byte_run_rle_encoder_top #(
  parameter int unsigned MAX_PACKET = 128,
  parameter int unsigned OUT_LANES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  brle_in_if.sink     in_i,
  brle_out_if.source  out_o
);

  localparam int unsigned ROWS = (MAX_PACKET + 1) / OUT_LANES + 1;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned LANE_W = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;

  logic                      accept;
  logic                      busy;
  brle_pkg::plan_t           plan;
  logic                      we;
  logic [ROW_W-1:0]          wr_row;
  logic [LANE_W-1:0]         wr_lane;
  logic [7:0]                wr_data;
  logic                      rd_en;
  logic [ROW_W-1:0]          rd_row;
  logic [OUT_LANES-1:0][7:0] rd_data;

  // Bytes are taken whenever the emitter has nothing left to send for the
  // previous byte; the output register decouples the result side.
  assign in_i.ready = !busy;
  assign accept     = in_i.valid && in_i.ready;

  brle_scan #(
    .MAX_PACKET (MAX_PACKET),
    .OUT_LANES  (OUT_LANES)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (in_i.data_byte),
    .last_i      (in_i.last_in_block),
    .plan_o      (plan),
    .we_o        (we),
    .wr_row_o    (wr_row),
    .wr_lane_o   (wr_lane),
    .wr_data_o   (wr_data)
  );

  brle_window_ram #(
    .MAX_PACKET (MAX_PACKET),
    .OUT_LANES  (OUT_LANES)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .wr_row_i  (wr_row),
    .wr_lane_i (wr_lane),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_row_i  (rd_row),
    .rd_data_o (rd_data)
  );

  brle_emit #(
    .MAX_PACKET (MAX_PACKET),
    .OUT_LANES  (OUT_LANES)
  ) u_emit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .plan_i    (plan),
    .busy_o    (busy),
    .rd_en_o   (rd_en),
    .rd_row_o  (rd_row),
    .rd_data_i (rd_data),
    .out_o     (out_o)
  );

  // The block end always flushes at least one packet.
  a_end_flushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.last_in_block |=> busy)
    else $error("block end did not start packet output");

  // A word never carries more bytes than there are lanes, and never none.
  a_lane_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.valid_bytes != 4'd0) && (out_o.valid_bytes <= 4'(OUT_LANES)))
    else $error("valid_bytes out of range");

  // The block's last byte closes a packet and is the last word of its input.
  a_block_end_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ends_block |-> out_o.last_of_run && out_o.ends_packet)
    else $error("ends_block on a word that does not close the run");

  // Packets are only settled by an accepted byte.
  a_plan_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plan.start |-> accept && !busy)
    else $error("packet settled without an accepted byte");

endmodule

`default_nettype wire
